// ===== rtl/saw_pkg.sv =====
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ package
// Types and constants shared by the ARQ engine, its result queue and top level.
// ----------------------------------------------------------------------------
package saw_pkg;

  localparam int unsigned PCT_FULL   = 100;
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  localparam logic [6:0] LOSS_THR_RST = 7'd20;
  localparam logic [7:0] RETRY_RST    = 8'd10;

  typedef enum logic [1:0] {
    FUNC_SEND    = 2'd0,
    FUNC_PDU     = 2'd1,
    FUNC_TIMEOUT = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_ACK      = 2'd1,
    KIND_DELIVER  = 2'd2,
    KIND_FINISHED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DELIVERED   = 2'd0,
    STATUS_UNCONFIRMED = 2'd1,
    STATUS_FAILED      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_LOCAL_PORT  = 2'd0,
    CFG_REMOTE_PORT = 2'd1,
    CFG_LOSS_THR    = 2'd2,
    CFG_RETRY_LIMIT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [6:0]  loss_thr;
    logic [7:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic        syn;
    logic        ack;
    logic        fin;
    logic [31:0] seq;
    logic [31:0] ack_number;
    logic [15:0] sport;
  } evt_t;

  typedef struct packed {
    kind_e       kind;
    logic        seq_out;
    logic [31:0] ack_number;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        ack_flag;
    logic [1:0]  send_status;
    logic        last;
  } res_t;

endpackage

// ===== rtl/saw_core.sv =====
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ decision core
// Holds the protocol state and the outcome window and turns one accepted
// event into zero, one or two results in the same cycle.
// ----------------------------------------------------------------------------
module saw_core #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  saw_pkg::evt_t evt_i,
  input  saw_pkg::cfg_t cfg_i,
  output logic [1:0]    push_n_o,
  output saw_pkg::res_t res0_o,
  output saw_pkg::res_t res1_o
);
  import saw_pkg::*;

  localparam int unsigned PtrW     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned CntW     = $clog2(WINDOW_LEN + 1);
  localparam int unsigned LossStep = PCT_FULL / WINDOW_LEN;

  logic                  seq_bit_q, seq_bit_d;
  logic                  waiting_q, waiting_d;
  logic                  out_seq_q, out_seq_d;
  logic [7:0]            made_q, made_d;
  logic [7:0]            allowed_q, allowed_d;
  logic [WINDOW_LEN-1:0] window_q, window_d;
  logic [PtrW-1:0]       ptr_q, ptr_d;
  logic [CntW-1:0]       fail_cnt_q, fail_cnt_d;

  logic [7:0] loss_pct;
  logic [7:0] retry_eff;
  logic       rec_en;
  logic       rec_ok;
  logic       ack_match;
  logic       flags_clear;
  res_t       data_res;
  res_t       fin_res;
  res_t       ack_res;
  res_t       dlv_res;

  // The window keeps a running failure count, so no population count is needed.
  assign loss_pct  = 8'(fail_cnt_q) * 8'(LossStep);
  assign retry_eff = (cfg_i.retry_limit == 8'd0) ? 8'd1 : cfg_i.retry_limit;

  assign ack_match   = !evt_i.syn && evt_i.ack && !evt_i.fin &&
                       (evt_i.ack_number == {31'd0, out_seq_q});
  assign flags_clear = !evt_i.syn && !evt_i.ack && !evt_i.fin;

  always_comb begin
    data_res       = '0;
    data_res.kind  = KIND_DATA;
    data_res.sport = cfg_i.local_port;
    data_res.dport = cfg_i.remote_port;
    data_res.last  = 1'b1;

    fin_res      = '0;
    fin_res.kind = KIND_FINISHED;
    fin_res.last = 1'b1;

    ack_res            = '0;
    ack_res.kind       = KIND_ACK;
    ack_res.ack_number = evt_i.seq;
    ack_res.sport      = cfg_i.local_port;
    ack_res.dport      = evt_i.sport;
    ack_res.ack_flag   = 1'b1;
    ack_res.last       = 1'b1;

    dlv_res      = '0;
    dlv_res.kind = KIND_DELIVER;
  end

  always_comb begin
    seq_bit_d = seq_bit_q;
    waiting_d = waiting_q;
    out_seq_d = out_seq_q;
    made_d    = made_q;
    allowed_d = allowed_q;
    rec_en    = 1'b0;
    rec_ok    = 1'b0;
    push_n_o  = 2'd0;
    res0_o    = data_res;
    res1_o    = ack_res;

    unique case (evt_i.func)
      FUNC_SEND: begin
        if (!waiting_q) begin
          allowed_d       = (loss_pct < {1'b0, cfg_i.loss_thr}) ? 8'd1 : retry_eff;
          out_seq_d       = seq_bit_q;
          seq_bit_d       = ~seq_bit_q;
          made_d          = 8'd1;
          waiting_d       = 1'b1;
          res0_o          = data_res;
          res0_o.seq_out  = seq_bit_q;
          push_n_o        = 2'd1;
        end
      end
      FUNC_PDU, FUNC_TIMEOUT: begin
        if (waiting_q) begin
          push_n_o = 2'd1;
          if (evt_i.func == FUNC_PDU && ack_match) begin
            rec_en             = 1'b1;
            rec_ok             = 1'b1;
            waiting_d          = 1'b0;
            res0_o             = fin_res;
            res0_o.send_status = STATUS_DELIVERED;
          end else if (made_q < allowed_q) begin
            // Attempts remain: retransmit the outstanding PDU.
            made_d         = made_q + 8'd1;
            res0_o         = data_res;
            res0_o.seq_out = out_seq_q;
          end else begin
            rec_en             = 1'b1;
            waiting_d          = 1'b0;
            res0_o             = fin_res;
            res0_o.send_status = (allowed_q == 8'd1) ? STATUS_UNCONFIRMED : STATUS_FAILED;
          end
        end else if (evt_i.func == FUNC_PDU && flags_clear) begin
          if (evt_i.seq == {31'd0, seq_bit_q}) begin
            seq_bit_d = ~seq_bit_q;
            res0_o    = dlv_res;
            res1_o    = ack_res;
            push_n_o  = 2'd2;
          end else begin
            res0_o   = ack_res;
            push_n_o = 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    window_d   = window_q;
    ptr_d      = ptr_q;
    fail_cnt_d = fail_cnt_q;
    if (rec_en) begin
      window_d[ptr_q] = rec_ok;
      if (rec_ok && !window_q[ptr_q]) begin
        fail_cnt_d = fail_cnt_q - 1'b1;
      end else if (!rec_ok && window_q[ptr_q]) begin
        fail_cnt_d = fail_cnt_q + 1'b1;
      end
      ptr_d = (ptr_q == PtrW'(WINDOW_LEN - 1)) ? '0 : ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_bit_q  <= 1'b0;
      waiting_q  <= 1'b0;
      out_seq_q  <= 1'b0;
      made_q     <= 8'd0;
      allowed_q  <= 8'd0;
      window_q   <= '1;
      ptr_q      <= '0;
      fail_cnt_q <= '0;
    end else if (accept_i) begin
      seq_bit_q  <= seq_bit_d;
      waiting_q  <= waiting_d;
      out_seq_q  <= out_seq_d;
      made_q     <= made_d;
      allowed_q  <= allowed_d;
      window_q   <= window_d;
      ptr_q      <= ptr_d;
      fail_cnt_q <= fail_cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    waiting_q |-> (allowed_q != 8'd0) && (made_q <= allowed_q))
    else $error("attempt count out of range while waiting");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fail_cnt_q <= CntW'(WINDOW_LEN)) && (ptr_q <= PtrW'(WINDOW_LEN - 1)))
    else $error("outcome window bookkeeping out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !waiting_q && evt_i.func == FUNC_SEND) |=>
      waiting_q && (out_seq_q != seq_bit_q) && (made_q == 8'd1))
    else $error("send request did not start a wait");

endmodule

// ===== rtl/saw_outq.sv =====
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ result queue
// Small FIFO that takes up to two results per cycle and hands out one per
// transfer; it separates the event side from the result side.
// ----------------------------------------------------------------------------
module saw_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_n_i,
  input  saw_pkg::res_t res0_i,
  input  saw_pkg::res_t res1_i,
  output logic          stall_o,
  input  logic          pop_i,
  output logic          valid_o,
  output saw_pkg::res_t head_o
);
  import saw_pkg::*;

  res_t                  mem [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OUTQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUTQ_CNT_W-1:0] count_q, count_d;
  logic                  pop;

  // Room for two results is always kept before another event is taken.
  assign stall_o = (count_q > OUTQ_CNT_W'(OUTQ_DEPTH - 2));
  assign valid_o = (count_q != '0);
  assign head_o  = mem[rd_ptr_q];
  assign pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q + OUTQ_PTR_W'(push_n_i);
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + OUTQ_CNT_W'(push_n_i) - OUTQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem[wr_ptr_q] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      mem[wr_ptr_q + 1'b1] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= OUTQ_CNT_W'(OUTQ_DEPTH))
    else $error("result queue fill level above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> (count_q + OUTQ_CNT_W'(push_n_i) <= OUTQ_CNT_W'(OUTQ_DEPTH)))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == OUTQ_CNT_W'(OUTQ_DEPTH)) || (OUTQ_PTR_W'(count_q) == wr_ptr_q - rd_ptr_q))
    else $error("result queue pointers disagree with fill level");

endmodule

// ===== rtl/stop_and_wait_partial_reliability_arq.sv =====
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ with partial reliability
// Top level: configuration registers, decision core and result queue.
// ----------------------------------------------------------------------------
// Results are registered in the result queue and offered in order from its head.
// One event per cycle is taken while the result queue does not stall; the decision
// core settles each event in the cycle it is taken, and only the result queue's
// one-per-cycle drain limits the rate, so an in-order data PDU yields two results
// (deliver plus ACK). Reset clears all protocol state at once and marks every
// outcome window entry as acknowledged; events are taken right after reset.
module stop_and_wait_partial_reliability_arq #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic        pdu_syn_i,
  input  logic        pdu_ack_i,
  input  logic        pdu_fin_i,
  input  logic [31:0] pdu_seq_i,
  input  logic [31:0] pdu_ack_number_i,
  input  logic [15:0] pdu_source_port_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic        seq_out_o,
  output logic [31:0] ack_number_out_o,
  output logic [15:0] source_port_out_o,
  output logic [15:0] dest_port_out_o,
  output logic        ack_flag_out_o,
  output logic [1:0]  send_status_o,
  output logic        last_o
);
  import saw_pkg::*;

  cfg_t       cfg_q;
  evt_t       evt;
  logic       accept;
  logic [1:0] push_n;
  res_t       res0;
  res_t       res1;
  res_t       head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_port  <= 16'd0;
      cfg_q.remote_port <= 16'd0;
      cfg_q.loss_thr    <= LOSS_THR_RST;
      cfg_q.retry_limit <= RETRY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LOCAL_PORT:  cfg_q.local_port  <= cfg_data_i;
        CFG_REMOTE_PORT: cfg_q.remote_port <= cfg_data_i;
        CFG_LOSS_THR:    cfg_q.loss_thr    <= cfg_data_i[6:0];
        CFG_RETRY_LIMIT: cfg_q.retry_limit <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  assign evt = {func_i, pdu_syn_i, pdu_ack_i, pdu_fin_i, pdu_seq_i, pdu_ack_number_i,
                pdu_source_port_i};

  saw_core #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .evt_i    (evt),
    .cfg_i    (cfg_q),
    .push_n_o (push_n),
    .res0_o   (res0),
    .res1_o   (res1)
  );

  saw_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (accept ? push_n : 2'd0),
    .res0_i   (res0),
    .res1_i   (res1),
    .stall_o  (in_stall_o),
    .pop_i    (!out_stall_i),
    .valid_o  (out_valid_o),
    .head_o   (head)
  );

  assign kind_o            = head.kind;
  assign seq_out_o         = head.seq_out;
  assign ack_number_out_o  = head.ack_number;
  assign source_port_out_o = head.sport;
  assign dest_port_out_o   = head.dport;
  assign ack_flag_out_o    = head.ack_flag;
  assign send_status_o     = head.send_status;
  assign last_o            = head.last;

endmodule
